// ----- hw/rtl/ola_pkg.sv -----
// ----------------------------------------------------------------------------
// ola_pkg
// Shared types and constants for the ordered list block: sizes, command and
// status codes, the input and result words, and the RAM request bundle.
// ----------------------------------------------------------------------------
package ola_pkg;

  // store geometry
  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // command codes
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // input word
  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [DATA_W-1:0] entry_value;
    logic [1:0]               status;
    logic                     last;
  } out_word_t;

  // combinational result from the sequencer, which the output register takes
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

  // request to the entry store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ----- hw/rtl/ordered_list_append_delete.sv -----
// ----------------------------------------------------------------------------
// ordered_list_append_delete
// Ordered list of signed 32-bit values kept in a 32-entry RAM, head first.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (command, value) is taken on a rising edge with start high
//   and busy low. Append adds the value at the tail, or answers store full.
//   Delete removes the first equal entry and closes the gap; it answers
//   empty or not found where that applies. List returns every entry head to
//   tail, last set on the final one; an empty list gives one empty word.
//   Command code 3 is dropped with no answer.
//   Results appear on out_word with out_valid high for exactly one cycle;
//   the receiver cannot stall, so every word must be taken when shown.
// Timing:
//   Append is answered in the cycle right after acceptance and busy never
//   rises, so appends can be issued every cycle. List holds busy while it
//   reads the entries and streams one word per cycle. Delete searches by
//   reading each entry and then comparing it, and shifts each later entry
//   up by one; the single read port of the RAM sets this pace.
// Reset:
//   Synchronous active-low rst_n empties the list; RAM contents are not
//   cleared since entries beyond the count are never read.
// ----------------------------------------------------------------------------
module ordered_list_append_delete (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ola_pkg::in_word_t  in_word,
  output logic               out_valid,
  output ola_pkg::out_word_t out_word
);

  import ola_pkg::*;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  res_t              res;
  logic              out_valid_r;
  out_word_t         out_word_r;

  // entry store
  ola_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // command sequencer
  ola_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res       (res)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= res.word;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- hw/rtl/ola_ram.sv -----
// ----------------------------------------------------------------------------
// ola_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. No reset on the contents.
// ----------------------------------------------------------------------------
module ola_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/ola_seq.sv -----
// ----------------------------------------------------------------------------
// ola_seq
// Command sequencer: appends at the tail, searches and shifts the store for
// delete, and walks the store for list. Holds the entry count.
// ----------------------------------------------------------------------------
module ola_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  ola_pkg::in_word_t         in_word,
  output logic                      busy,
  output ola_pkg::ram_req_t         ram_req,
  input  logic [ola_pkg::DATA_W-1:0] ram_rdata,
  output ola_pkg::res_t             res
);

  import ola_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LIST  = 6'b000010,
    S_LWAIT = 6'b000100,
    S_SRD   = 6'b001000,
    S_SCMP  = 6'b010000,
    S_SHIFT = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  rp_r, rp_nxt;
  logic [CNT_W-1:0]  wp_r, wp_nxt;
  logic              pend_r, pend_nxt;
  logic              plast_r, plast_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  count_m1;
  logic              idx_is_last;

  assign busy        = (state_r != S_IDLE);
  assign count_m1    = count_r - CNT_W'(1);
  assign idx_is_last = ({{(CNT_W-ADDR_W){1'b0}}, idx_r} == count_m1);

  // next-state and datapath control
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    pend_nxt  = 1'b0;
    plast_nxt = plast_r;
    val_nxt   = val_r;
    ram_req   = '0;
    res       = '0;

    // listed entry comes back in the cycle after its read
    if (pend_r && (state_r == S_LIST || state_r == S_LWAIT)) begin
      res.valid            = 1'b1;
      res.word.entry_value = ram_rdata;
      res.word.status      = ST_OK;
      res.word.last        = plast_r;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_word.command)
            CMD_APPEND: begin
              res.valid     = 1'b1;
              res.word.last = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                res.word.status = ST_FULL;
              end else begin
                ram_req.we      = 1'b1;
                ram_req.waddr   = count_r[ADDR_W-1:0];
                ram_req.wdata   = in_word.value;
                count_nxt       = count_r + CNT_W'(1);
                res.word.status = ST_OK;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                res.valid       = 1'b1;
                res.word.status = ST_EMPTY;
                res.word.last   = 1'b1;
              end else begin
                val_nxt   = in_word.value;
                idx_nxt   = '0;
                state_nxt = S_SRD;
              end
            end
            CMD_LIST: begin
              if (count_r == '0) begin
                res.valid       = 1'b1;
                res.word.status = ST_EMPTY;
                res.word.last   = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // one read per cycle, head to tail
      S_LIST: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = idx_r;
        pend_nxt      = 1'b1;
        plast_nxt     = idx_is_last;
        if (idx_is_last) begin
          state_nxt = S_LWAIT;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end

      S_LWAIT: begin
        state_nxt = S_IDLE;
      end

      // search: read an entry
      S_SRD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = idx_r;
        state_nxt     = S_SCMP;
      end

      // search: compare it
      S_SCMP: begin
        if (ram_rdata == val_r) begin
          wp_nxt    = {{(CNT_W-ADDR_W){1'b0}}, idx_r};
          rp_nxt    = {{(CNT_W-ADDR_W){1'b0}}, idx_r} + CNT_W'(1);
          state_nxt = S_SHIFT;
        end else if (idx_is_last) begin
          res.valid       = 1'b1;
          res.word.status = ST_NOT_FOUND;
          res.word.last   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = S_SRD;
        end
      end

      // shift the tail up by one: read rp, write what came back to wp
      S_SHIFT: begin
        if (pend_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = wp_r[ADDR_W-1:0];
          ram_req.wdata = ram_rdata;
          wp_nxt        = wp_r + CNT_W'(1);
        end
        if (rp_r != count_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = rp_r[ADDR_W-1:0];
          pend_nxt      = 1'b1;
          rp_nxt        = rp_r + CNT_W'(1);
        end else if (!pend_r) begin
          count_nxt       = count_m1;
          res.valid       = 1'b1;
          res.word.status = ST_OK;
          res.word.last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    rp_r    <= rp_nxt;
    wp_r    <= wp_nxt;
    plast_r <= plast_nxt;
    val_r   <= val_nxt;
  end

endmodule
